/* sv/plid_pkg.sv */
// ----------------------------------------------------------------------------
// plid_pkg: shared types and codes for the positional list unit
// Request and response payloads, operation and status codes, cell command.
// ----------------------------------------------------------------------------
package plid_pkg;

    localparam int POS_W    = 5;
    localparam int IN_KEY_W = 32;
    localparam int FIDX_W   = 4;
    localparam int OCNT_W   = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0]          op;
        logic [POS_W-1:0]    position;
        logic [IN_KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [FIDX_W-1:0] found_index;
        logic [OCNT_W-1:0] count;
    } rsp_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;        // shift up from position, load key at position
        logic del;        // shift down from position
        logic load_hit;   // capture key compare
        logic shift_hit;  // move hit flags one cell toward cell 0
    } cell_cmd_t;

endpackage

/* sv/plid_cell.sv */
// ----------------------------------------------------------------------------
// plid_cell: one list slot
// Holds one key and a hit flag; shifts with its neighbors on insert/delete.
// ----------------------------------------------------------------------------
module plid_cell
    import plid_pkg::*;
#(
    parameter int KEY_WIDTH = 32,
    parameter int CMP_W     = 5,
    parameter int IDX       = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  logic [CMP_W-1:0]     pos,
    input  logic [CMP_W-1:0]     cnt,
    input  logic [KEY_WIDTH-1:0] key,
    input  logic [KEY_WIDTH-1:0] left_entry,
    input  logic [KEY_WIDTH-1:0] right_entry,
    input  logic                 right_hit,
    output logic [KEY_WIDTH-1:0] entry,
    output logic                 hit
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

    logic [KEY_WIDTH-1:0] entry_reg, entry_next;
    logic                 hit_reg, hit_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (MY_IDX == pos)
                entry_next = key;
            else if (MY_IDX > pos)
                entry_next = left_entry;
        end
        else if (cmd.del && (MY_IDX >= pos))
        begin
            entry_next = right_entry;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (cmd.load_hit)
            hit_next = (entry_reg == key) && (MY_IDX < cnt);
        else if (cmd.shift_hit)
            hit_next = right_hit;
    end

    // key storage: no reset, only slots below the count are ever read
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

/* sv/positional_list_insert_delete_search_unit.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete_search_unit: ordered key list
// Insert at position, delete at position, lowest-index search, on a row of
// cells that each hold one key.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------
//  req     | in  | req_valid / req_ready | op, position, key       (req_t)
//  rsp     | out | rsp_valid / rsp_ready | status, found_index, count (rsp_t)
//
//  Insert, delete, unused op codes and a search of an empty list: the response
//  is loaded at the transfer edge and is valid in the next cycle.
//  Search compares all cells at the transfer edge, then walks the hit flags down
//  the row one slot a cycle up to the first hit, or to the last slot on a miss.
//  One request is in flight at a time; req_ready is low during a search walk
//  and while a response sits in the output register with rsp_ready low.
//  Reset clears the count, the hit flags and the control; keys are not reset.
//
module positional_list_insert_delete_search_unit
    import plid_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic                 accept;
    logic [CMP_W-1:0]     pos_ext, cnt_ext;
    logic [KEY_WIDTH-1:0] key_m;
    logic                 full, empty, ins_ok, del_ok, is_search;
    logic [2:0]           imm_status;
    logic [IDX_W-1:0]     last_idx;
    cell_cmd_t            cmd;

    logic [KEY_WIDTH-1:0] entry_w [DEPTH];
    logic                 hit_w   [DEPTH];

    assign accept    = req_valid && req_ready;
    assign pos_ext   = CMP_W'(req.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign key_m     = KEY_WIDTH'(req.key);
    assign full      = (cnt_ext == CMP_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ins_ok    = (req.op == OP_INSERT) && !full && (pos_ext <= cnt_ext);
    assign del_ok    = (req.op == OP_DELETE) && !empty && (pos_ext < cnt_ext);
    assign is_search = (req.op == OP_SEARCH);
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));

    // status for everything settled at transfer time
    always_comb
    begin
        case (req.op)
            OP_INSERT: imm_status = full ? ST_FULL :
                                    (pos_ext > cnt_ext) ? ST_BADPOS : ST_OK;
            OP_DELETE: imm_status = empty ? ST_EMPTY :
                                    (pos_ext >= cnt_ext) ? ST_BADPOS : ST_OK;
            OP_SEARCH: imm_status = ST_NOTFOUND;  // only used on an empty list
            default:   imm_status = ST_OK;
        endcase
    end

    // one request at a time; wait for the output register to free up
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        cmd            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.ins      = ins_ok;
                    cmd.del      = del_ok;
                    cmd.load_hit = is_search;
                    if (ins_ok)
                        count_next = count_reg + CNT_W'(1);
                    else if (del_ok)
                        count_next = count_reg - CNT_W'(1);

                    if (is_search && !empty)
                    begin
                        state_next = S_SCAN;
                        scan_next  = '0;
                    end
                    else
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.status      = imm_status;
                        rsp_next.found_index = '0;
                        rsp_next.count       = OCNT_W'(count_next);
                    end
                end
            end

            S_SCAN:
            begin
                // cell 0 holds the hit flag of slot scan_reg
                if (hit_w[0])
                begin
                    state_next           = S_IDLE;
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = ST_OK;
                    rsp_next.found_index = FIDX_W'(scan_reg);
                    rsp_next.count       = OCNT_W'(count_reg);
                end
                else if (scan_reg == last_idx)
                begin
                    state_next           = S_IDLE;
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = ST_NOTFOUND;
                    rsp_next.found_index = '0;
                    rsp_next.count       = OCNT_W'(count_reg);
                end
                else
                begin
                    cmd.shift_hit = 1'b1;
                    scan_next     = scan_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // cell row: slot i talks to slots i-1 and i+1
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left_e, right_e;
        logic                 right_h;

        if (i == 0)
        begin : g_first
            assign left_e = key_m;
        end
        else
        begin : g_mid_l
            assign left_e = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = key_m;
            assign right_h = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_e = entry_w[i+1];
            assign right_h = hit_w[i+1];
        end

        plid_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CMP_W     (CMP_W),
            .IDX       (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .pos         (pos_ext),
            .cnt         (cnt_ext),
            .key         (key_m),
            .left_entry  (left_e),
            .right_entry (right_e),
            .right_hit   (right_h),
            .entry       (entry_w[i]),
            .hit         (hit_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
